FILE: hdl/pvv_pkg.sv
// types and constants shared by the polygon vertex validator modules
package pvv_pkg;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_EQUAL     = 3'd1,
      STAT_COLLINEAR = 3'd2,
      STAT_CROSSING  = 3'd3,
      STAT_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      logic               action;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [6:0] vertex_count;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       issue;
      logic       rsp_load;
      logic       commit_add;
      logic       commit_clear;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic is_clear;
      logic full;
      logic few;
      logic rd_last;
      logic eq;
      logic col;
      logic hit;
   } flags_type;

   localparam int COUNT_OUT_W = 7;
   localparam int DRAIN_LEN   = 5;
   localparam int DRAIN_W     = $clog2(DRAIN_LEN);

endpackage

FILE: hdl/pvv_ctrl.sv
// controller state machine: item sequencing, edge sweep and result hand-off
module pvv_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pvv_pkg::cmd_type   cmd,
   input  pvv_pkg::flags_type flags
);
   import pvv_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_SWEEP = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [DRAIN_W-1:0] drain_ff, drain_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         code;

   always_comb begin
      if (flags.is_clear) begin
         code = STAT_OK;
      end else if (flags.full) begin
         code = STAT_FULL;
      end else if (flags.few) begin
         code = STAT_OK;
      end else if (flags.eq) begin
         code = STAT_EQUAL;
      end else if (flags.col) begin
         code = STAT_COLLINEAR;
      end else if (flags.hit) begin
         code = STAT_CROSSING;
      end else begin
         code = STAT_OK;
      end
   end

   always_comb begin
      state_in     = state_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.status   = STAT_OK;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (flags.is_clear || flags.full || flags.few) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            cmd.issue = 1'b1;
            if (flags.rd_last) begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_W'(DRAIN_LEN - 1)) begin
               state_in = ST_DONE;
            end else begin
               drain_in = drain_ff + DRAIN_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load     = 1'b1;
               cmd.status       = code;
               cmd.commit_add   = !flags.is_clear && (code == STAT_OK);
               cmd.commit_clear = flags.is_clear;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_issue_only_for_check: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (!flags.few && !flags.full && !flags.is_clear))
      else $error("edge sweep started for an item that needs none");

   a_sweep_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |=> (state_ff == ST_SWEEP || state_ff == ST_DRAIN))
      else $error("sweep left without draining the edge pipeline");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("result item dropped before it was taken");

endmodule

FILE: hdl/pvv_datapath.sv
// datapath: vertex store, edge intersection pipeline and result register
module pvv_datapath #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  pvv_pkg::req_type   req_data,
   input  pvv_pkg::cmd_type   cmd,
   output pvv_pkg::flags_type flags,
   output pvv_pkg::rsp_type   rsp_data
);
   import pvv_pkg::*;

   localparam int CW    = COORD_BITS;
   localparam int DW    = CW + 1;
   localparam int PW    = 2 * DW;
   localparam int SW    = PW + 1;
   localparam int AW    = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);

   logic [2*CW-1:0] mem [MAX_VERTICES];

   logic signed [CW-1:0] in_x, in_y;
   logic signed [CW-1:0] last_x_ff, last_y_ff;
   logic signed [DW-1:0] dx12_ff, dy12_ff, dlx_ff, dly_ff;
   logic signed [PW-1:0] pc0_ff, pc1_ff;
   logic                 is_clear_ff;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] rd_addr_ff, rd_addr_in;
   logic [CNT_W+COUNT_OUT_W-1:0] cnt_wide;

   logic [2*CW-1:0]      rd_data_ff;
   logic signed [CW-1:0] d_x, d_y, c_x, c_y;
   logic [2*CW-1:0]      c_ff;
   logic                 s1_v_ff, s1_first_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic signed [DW-1:0] dx34_ff, dy34_ff, dx13_ff, dy13_ff;
   logic signed [PW-1:0] prod_ff [6];
   logic signed [SW-1:0] den_ff, nu_ff, nv_ff;
   logic                 meet;
   logic                 hit_ff, hit_in;

   if (CW > 16) begin : g_wide
      assign in_x = {{(CW - 16){1'b0}}, req_data.vx};
      assign in_y = {{(CW - 16){1'b0}}, req_data.vy};
   end else begin : g_narrow
      assign in_x = req_data.vx[CW-1:0];
      assign in_y = req_data.vy[CW-1:0];
   end

   // item capture and polygon tail
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_clear_ff <= req_data.action;
         dx12_ff     <= {in_x[CW-1], in_x} - {last_x_ff[CW-1], last_x_ff};
         dy12_ff     <= {in_y[CW-1], in_y} - {last_y_ff[CW-1], last_y_ff};
      end
      if (cmd.commit_add) begin
         mem[cnt_ff[AW-1:0]] <= {last_x_ff + CW'(dx12_ff), last_y_ff + CW'(dy12_ff)};
         dlx_ff              <= dx12_ff;
         dly_ff              <= dy12_ff;
      end
      if (reset) begin
         last_x_ff <= '0;
         last_y_ff <= '0;
      end else if (cmd.commit_add) begin
         last_x_ff <= last_x_ff + CW'(dx12_ff);
         last_y_ff <= last_y_ff + CW'(dy12_ff);
      end
      pc0_ff <= dly_ff * dx12_ff;
      pc1_ff <= dlx_ff * dy12_ff;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.commit_clear) begin
         cnt_in = '0;
      end else if (cmd.commit_add) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      rd_addr_in = rd_addr_ff;
      if (cmd.load) begin
         rd_addr_in = '0;
      end else if (cmd.issue) begin
         rd_addr_in = rd_addr_ff + CNT_W'(1);
      end
   end

   assign cnt_wide = {{COUNT_OUT_W{1'b0}}, cnt_in};

   // edge sweep: read, differences, products, cross terms, range test
   assign d_x = rd_data_ff[2*CW-1:CW];
   assign d_y = rd_data_ff[CW-1:0];
   assign c_x = c_ff[2*CW-1:CW];
   assign c_y = c_ff[CW-1:0];

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr_ff[AW-1:0]];
      if (s1_v_ff) begin
         c_ff <= rd_data_ff;
      end
      dx34_ff    <= {d_x[CW-1], d_x} - {c_x[CW-1], c_x};
      dy34_ff    <= {d_y[CW-1], d_y} - {c_y[CW-1], c_y};
      dx13_ff    <= {last_x_ff[CW-1], last_x_ff} - {c_x[CW-1], c_x};
      dy13_ff    <= {last_y_ff[CW-1], last_y_ff} - {c_y[CW-1], c_y};
      prod_ff[0] <= dy34_ff * dx12_ff;
      prod_ff[1] <= dx34_ff * dy12_ff;
      prod_ff[2] <= dx34_ff * dy13_ff;
      prod_ff[3] <= dy34_ff * dx13_ff;
      prod_ff[4] <= dx12_ff * dy13_ff;
      prod_ff[5] <= dy12_ff * dx13_ff;
      den_ff     <= {prod_ff[0][PW-1], prod_ff[0]} - {prod_ff[1][PW-1], prod_ff[1]};
      nu_ff      <= {prod_ff[2][PW-1], prod_ff[2]} - {prod_ff[3][PW-1], prod_ff[3]};
      nv_ff      <= {prod_ff[4][PW-1], prod_ff[4]} - {prod_ff[5][PW-1], prod_ff[5]};
      s1_first_ff <= (rd_addr_ff == '0);
   end

   // sign of the denominator picks the direction of the range test
   assign meet = ((den_ff > 0) && (nu_ff >= 0) && (nu_ff <= den_ff)
                               && (nv_ff >= 0) && (nv_ff <= den_ff))
              || ((den_ff < 0) && (nu_ff <= 0) && (nu_ff >= den_ff)
                               && (nv_ff <= 0) && (nv_ff >= den_ff));

   assign hit_in = cmd.load ? 1'b0 : (hit_ff | (s4_v_ff & meet));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         rd_addr_ff <= '0;
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         s3_v_ff    <= 1'b0;
         s4_v_ff    <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         rd_addr_ff <= rd_addr_in;
         s1_v_ff    <= cmd.issue;
         s2_v_ff    <= s1_v_ff && !s1_first_ff;
         s3_v_ff    <= s2_v_ff;
         s4_v_ff    <= s3_v_ff;
         hit_ff     <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data.status       <= cmd.status;
         rsp_data.vertex_count <= cnt_wide[COUNT_OUT_W-1:0];
      end
   end

   assign flags.is_clear = is_clear_ff;
   assign flags.full     = (cnt_ff == CNT_W'(MAX_VERTICES));
   assign flags.few      = (cnt_ff < CNT_W'(2));
   assign flags.rd_last  = (rd_addr_ff == cnt_ff - CNT_W'(2));
   assign flags.eq       = (dx12_ff == '0) && (dy12_ff == '0);
   assign flags.col      = (pc0_ff == pc1_ff);
   assign flags.hit      = hit_ff;

   a_load_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !(s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff))
      else $error("item taken while the edge pipeline still held work");

   a_result_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff))
      else $error("result latched before the edge pipeline drained");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_add |-> (cnt_ff < CNT_W'(MAX_VERTICES)))
      else $error("vertex appended to a full store");

endmodule

FILE: hdl/polygon_vertex_validator.sv
// top level of the polygon vertex validator
//
//   channel   direction  handshake             payload
//   req_      in         req_valid / req_ready  pvv_pkg::req_type (action, vx, vy)
//   rsp_      out        rsp_valid / rsp_ready  pvv_pkg::rsp_type (status, vertex_count)
//
// clear, full store and fewer than two stored vertices: no edge sweep
// other adds: an edge sweep, one store read per cycle
//   through the edge pipeline (read, differences, products, cross terms, range test)
// synchronous reset empties the polygon; no clearing pass over the store
// a result waits in the output register while the next item is taken
module polygon_vertex_validator #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pvv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pvv_pkg::rsp_type rsp_data
);
   import pvv_pkg::*;

   cmd_type   cmd;
   flags_type flags;

   pvv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .flags     (flags)
   );

   pvv_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .flags    (flags),
      .rsp_data (rsp_data)
   );

endmodule

FILE: test/polygon_vertex_validator_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the polygon vertex validator: directed table then random polygons
module polygon_vertex_validator_tb;
   import pvv_pkg::*;

   localparam int   MAX_VERTICES  = 64;
   localparam int   COORD_BITS    = 16;
   localparam int   RANDOM_ITEMS  = 1000;
   localparam int   PHASE_COUNT   = 4;
   localparam int   HOLD_CYCLES   = 400;
   localparam int   SETTLE_CYCLES = 100;
   localparam int   CYCLE_LIMIT   = 1_000_000;
   localparam int   LONG_RUN      = 100;
   localparam logic ACT_ADD       = 1'b0;
   localparam logic ACT_CLEAR     = 1'b1;

   typedef struct packed {
      logic               action;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic               given;
      status_type         status;
      logic [6:0]         vertex_count;
   } plan_row_type;

   localparam int PLAN_ROWS = 24;
   localparam int FILL_ROW  = 21;

   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{ACT_CLEAR, 16'hffff,   16'h8000,   1'b1, STAT_OK,        7'd0},
      '{ACT_ADD,   16'h8000,   16'h8000,   1'b1, STAT_OK,        7'd1},
      '{ACT_ADD,   16'h8000,   16'h8000,   1'b1, STAT_OK,        7'd2},
      '{ACT_ADD,   16'h8000,   16'h8000,   1'b1, STAT_EQUAL,     7'd2},
      '{ACT_ADD,   16'h7fff,   16'h7fff,   1'b1, STAT_COLLINEAR, 7'd2},
      '{ACT_CLEAR, 16'h7fff,   16'h7fff,   1'b1, STAT_OK,        7'd0},
      '{ACT_ADD,   16'sd0,     16'sd0,     1'b1, STAT_OK,        7'd1},
      '{ACT_ADD,   16'sd100,   16'sd0,     1'b1, STAT_OK,        7'd2},
      '{ACT_ADD,   16'sd100,   16'sd100,   1'b1, STAT_OK,        7'd3},
      '{ACT_ADD,   16'sd0,     16'sd100,   1'b1, STAT_OK,        7'd4},
      '{ACT_ADD,   16'sd50,    -16'sd50,   1'b1, STAT_CROSSING,  7'd4},
      '{ACT_ADD,   16'sd0,     16'sd0,     1'b1, STAT_CROSSING,  7'd4},
      '{ACT_ADD,   16'sd50,    16'sd100,   1'b1, STAT_COLLINEAR, 7'd4},
      '{ACT_ADD,   -16'sd50,   16'sd100,   1'b1, STAT_COLLINEAR, 7'd4},
      '{ACT_ADD,   16'sd0,     16'sd100,   1'b1, STAT_EQUAL,     7'd4},
      '{ACT_ADD,   -16'sd10,   16'sd50,    1'b0, STAT_OK,        7'd0},
      '{ACT_ADD,   16'sd150,   16'sd50,    1'b0, STAT_OK,        7'd0},
      '{ACT_ADD,   16'sd50,    16'sd50,    1'b0, STAT_OK,        7'd0},
      '{ACT_ADD,   16'h7fff,   16'h8000,   1'b0, STAT_OK,        7'd0},
      '{ACT_ADD,   16'h8000,   16'h7fff,   1'b0, STAT_OK,        7'd0},
      '{ACT_CLEAR, 16'sd0,     16'sd0,     1'b1, STAT_OK,        7'd0},
      '{ACT_ADD,   16'sd31500, 16'sd31504, 1'b1, STAT_FULL,      7'd64},
      '{ACT_ADD,   16'h8000,   16'h7fff,   1'b1, STAT_FULL,      7'd64},
      '{ACT_CLEAR, 16'h5555,   16'haaaa,   1'b1, STAT_OK,        7'd0}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   longint  poly_x [MAX_VERTICES];
   longint  poly_y [MAX_VERTICES];
   int      poly_count = 0;
   rsp_type awaited_results [$];

   int      send_idle_pct  = 0;
   int      rsp_stall_pct  = 0;
   int      rsp_hold_left  = 0;
   int      mismatch_count = 0;
   int      cycle_count    = 0;

   // current random polygon: a convex parabolic chain
   int      chain_x0, chain_y0, chain_sx, chain_a, chain_len, chain_step;
   bit      chain_flip_x, chain_flip_y;

   polygon_vertex_validator #(
      .MAX_VERTICES(MAX_VERTICES),
      .COORD_BITS  (COORD_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
   end

   function automatic bit segments_cross(longint ax, longint ay, longint bx, longint by,
                                         longint cx, longint cy, longint qx, longint qy);
      longint ex, ey, fx, fy, gx, gy, den, nu, nv;
      ex  = bx - ax;
      ey  = by - ay;
      fx  = qx - cx;
      fy  = qy - cy;
      gx  = ax - cx;
      gy  = ay - cy;
      den = fy * ex - fx * ey;
      nu  = fx * gy - fy * gx;
      nv  = ex * gy - ey * gx;
      if (den == 0) begin
         return 1'b0;
      end
      if (den < 0) begin
         den = -den;
         nu  = -nu;
         nv  = -nv;
      end
      return nu >= 0 && nu <= den && nv >= 0 && nv <= den;
   endfunction

   function automatic rsp_type validate_vertex(req_type item);
      rsp_type    res;
      status_type st;
      longint     px, py, lx, ly, den;
      int         n;
      n  = poly_count;
      st = STAT_OK;
      px = longint'(item.vx);
      py = longint'(item.vy);
      if (item.action == ACT_CLEAR) begin
         poly_count = 0;
      end else begin
         if (n >= MAX_VERTICES) begin
            st = STAT_FULL;
         end else if (n >= 2) begin
            lx  = poly_x[n-1];
            ly  = poly_y[n-1];
            den = (ly - poly_y[n-2]) * (px - lx) - (lx - poly_x[n-2]) * (py - ly);
            if (px == lx && py == ly) begin
               st = STAT_EQUAL;
            end else if (den == 0) begin
               st = STAT_COLLINEAR;
            end else begin
               for (int i = 1; i + 1 < n; i++) begin
                  if (st == STAT_OK && segments_cross(lx, ly, px, py, poly_x[i-1], poly_y[i-1],
                                                      poly_x[i], poly_y[i])) begin
                     st = STAT_CROSSING;
                  end
               end
            end
         end
         if (st == STAT_OK) begin
            poly_x[n]  = px;
            poly_y[n]  = py;
            poly_count = n + 1;
         end
      end
      res.status       = st;
      res.vertex_count = 7'(poly_count);
      return res;
   endfunction

   function automatic req_type next_polygon_item(bit tidy);
      req_type     item;
      int unsigned pick;
      int          last, m, j, k;
      longint      px, py;
      item.action = ACT_ADD;
      item.vx     = 16'($urandom);
      item.vy     = 16'($urandom);
      pick        = $urandom_range(0, 99);
      last        = poly_count - 1;
      if (tidy && $urandom_range(0, 3) != 0) begin
         pick = 99;
      end
      if (pick < 4 && !tidy) begin
         item.action = ACT_CLEAR;
      end else if (pick >= 4 && pick < 12 && poly_count >= 1) begin
         item.vx = 16'(poly_x[last]);
         item.vy = 16'(poly_y[last]);
      end else if (pick >= 12 && pick < 20 && poly_count >= 2) begin
         m = $urandom_range(0, 3);
         m = (m < 2) ? m - 2 : m;
         px = poly_x[last] + m * (poly_x[last] - poly_x[last-1]);
         py = poly_y[last] + m * (poly_y[last] - poly_y[last-1]);
         item.vx = 16'(px);
         item.vy = 16'(py);
      end else if (pick >= 20 && pick < 26 && poly_count >= 4) begin
         // aim through an earlier vertex
         j = $urandom_range(0, poly_count - 3);
         item.vx = 16'(2 * poly_x[j] - poly_x[last]);
         item.vy = 16'(2 * poly_y[j] - poly_y[last]);
      end else if (pick >= 32 && chain_step <= chain_len) begin
         k = chain_step;
         chain_step++;
         px = longint'(chain_flip_x ? chain_x0 + chain_sx * (chain_len - k)
                                    : chain_x0 + chain_sx * k);
         py = longint'(chain_flip_y ? chain_y0 + chain_a * (chain_len * chain_len - k * k)
                                    : chain_y0 + chain_a * k * k);
         item.vx = 16'(px);
         item.vy = 16'(py);
      end
      return item;
   endfunction

   task automatic offer_item(input req_type item, input bit use_given, input rsp_type given);
      rsp_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      predicted = validate_vertex(item);
      awaited_results.push_back(use_given ? given : predicted);
   endtask

   initial begin
      rsp_type wanted;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected item: status %0d, vertex_count %0d",
                      rsp_data.status, rsp_data.vertex_count);
               mismatch_count++;
            end else begin
               wanted = awaited_results.pop_front();
               if (rsp_data.status !== wanted.status) begin
                  $error("status: expected %0d, got %0d", wanted.status, rsp_data.status);
                  mismatch_count++;
               end
               if (rsp_data.vertex_count !== wanted.vertex_count) begin
                  $error("vertex_count: expected %0d, got %0d",
                         wanted.vertex_count, rsp_data.vertex_count);
                  mismatch_count++;
               end
            end
         end
         if (rsp_hold_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      req_type item;
      rsp_type given;
      int      items_sent;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < PLAN_ROWS; k++) begin
         if (k == FILL_ROW) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
               item.action = ACT_ADD;
               item.vx     = 16'(-31500 + i * 1000);
               item.vy     = 16'(-32000 + i * i * 16);
               offer_item(item, 1'b0, '0);
            end
         end
         item.action        = directed_plan[k].action;
         item.vx            = directed_plan[k].vx;
         item.vy            = directed_plan[k].vy;
         given.status       = directed_plan[k].status;
         given.vertex_count = directed_plan[k].vertex_count;
         offer_item(item, directed_plan[k].given, given);
      end
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 83;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 83;
            end
            default: begin
               send_idle_pct = 18;
               rsp_stall_pct = 18;
            end
         endcase
         items_sent = 0;
         while (items_sent < RANDOM_ITEMS / PHASE_COUNT) begin
            chain_len    = ($urandom_range(0, 3) == 0) ? LONG_RUN : $urandom_range(3, 20);
            chain_sx     = $urandom_range(1, 30000 / chain_len);
            chain_a      = $urandom_range(1, 30000 / (chain_len * chain_len));
            chain_x0     = int'($urandom_range(0, 65535 - chain_sx * chain_len)) - 32768;
            chain_y0     = int'($urandom_range(0, 65535 - chain_a * chain_len * chain_len))
                           - 32768;
            chain_flip_x = 1'($urandom_range(0, 1));
            chain_flip_y = 1'($urandom_range(0, 1));
            chain_step   = 0;
            for (int s = 0; s < chain_len; s++) begin
               if (ph == 0 && items_sent == 60) begin
                  rsp_hold_left = HOLD_CYCLES;
               end
               offer_item(next_polygon_item(chain_len == LONG_RUN), 1'b0, '0);
               items_sent++;
            end
            item.action = ACT_CLEAR;
            item.vx     = 16'($urandom);
            item.vy     = 16'($urandom);
            offer_item(item, 1'b0, '0);
            items_sent++;
         end
         req_valid <= 1'b0;
         while (awaited_results.size() != 0) @(posedge clock);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
